@@ design/vasc_pkg.sv @@
// ----------------------------------------------------------------------------
// vasc_pkg
// Shared widths, codes and types of the vehicle axle and speed classifier.
// ----------------------------------------------------------------------------
package vasc_pkg;

  localparam int OP_W     = 2;
  localparam int TIME_W   = 32;
  localparam int DIST_W   = 16;
  localparam int TICK_W   = 16;
  localparam int AXLE_W   = 8;
  localparam int SPEED_W  = 22;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_AXLES_DEF = 255;

  // Speed reported when both pulses carry the same timestamp (65535 * 36).
  localparam logic [SPEED_W-1:0] SPEED_MAX = 22'd2359260;

  localparam logic [DIST_W-1:0] DIST_RESET    = 16'd1000;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd700;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_FIRST  = 2'd0;
  localparam op_t OP_SECOND = 2'd1;
  localparam op_t OP_TICK   = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DISTANCE = 2'd0;
  localparam cfg_idx_t CFG_TIMEOUT  = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Packed so that heavy_vehicle lands in bit 0.
  typedef struct packed {
    logic               speed_saturated;
    logic [SPEED_W-1:0] speed_tenths_kmh;
    logic [AXLE_W-1:0]  axle_total;
    logic               heavy_vehicle;
  } result_t;

endpackage

@@ design/vasc_divider.sv @@
// ----------------------------------------------------------------------------
// vasc_divider
// Bit-serial restoring divider: distance / dt, one quotient bit per cycle,
// then the quotient is scaled by 36 to tenths of km/h.
// ----------------------------------------------------------------------------
module vasc_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [vasc_pkg::DIST_W-1:0]         dividend,
  input  logic [vasc_pkg::TIME_W-1:0]         divisor,
  output vasc_pkg::div_status_t               status,
  output logic [vasc_pkg::SPEED_W-1:0]        speed
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_SCALE = 3'b100
  } div_state_t;

  div_state_t                     state;
  logic [3:0]                     step;
  logic [vasc_pkg::DIST_W-1:0]    num;
  logic [vasc_pkg::DIST_W-1:0]    rem;
  logic [vasc_pkg::DIST_W-1:0]    quo;
  logic [vasc_pkg::TIME_W-1:0]    den;
  logic                           done;

  logic [vasc_pkg::DIST_W:0]      shifted;
  logic [vasc_pkg::DIST_W:0]      diff;
  logic                           fits;
  logic [vasc_pkg::DIST_W-1:0]    rem_next;

  // The partial remainder never exceeds the dividend, so only the low
  // divisor bits take part in the compare; any high bit set means no fit.
  always_comb begin
    shifted  = {rem, num[vasc_pkg::DIST_W-1]};
    diff     = shifted - den[vasc_pkg::DIST_W:0];
    fits     = (den[vasc_pkg::TIME_W-1:vasc_pkg::DIST_W+1] == '0) &&
               (shifted >= den[vasc_pkg::DIST_W:0]);
    rem_next = fits ? diff[vasc_pkg::DIST_W-1:0] : shifted[vasc_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            step  <= '0;
          end
        end
        S_RUN: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          num <= dividend;
          den <= divisor;
          rem <= '0;
          quo <= '0;
        end
      end
      S_RUN: begin
        num <= {num[vasc_pkg::DIST_W-2:0], 1'b0};
        rem <= rem_next;
        quo <= {quo[vasc_pkg::DIST_W-2:0], fits};
      end
      S_SCALE: begin
        // q * 36 = q * 32 + q * 4
        speed <= {1'b0, quo, 5'd0} + {4'd0, quo, 2'd0};
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = done;

endmodule

@@ design/vasc_out_reg.sv @@
// ----------------------------------------------------------------------------
// vasc_out_reg
// Output register that holds one classification result until it is taken.
// ----------------------------------------------------------------------------
module vasc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  vasc_pkg::result_t data,
  output logic              valid,
  input  logic              ready,
  output vasc_pkg::result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

endmodule

@@ design/vehicle_axle_speed_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// vehicle_axle_speed_classifier_unit
// Latency: a closing tick request presents its result on the next cycle.
// Throughput: one request per cycle while the result register has room, but a
// first second-sensor request with a nonzero time difference holds off input
// while the bit-serial divider produces 16 quotient bits, scales and hands back.
// Reset: synchronous; clears the reading and loads distance 1000, timeout 700.
// ----------------------------------------------------------------------------
module vehicle_axle_speed_classifier_unit #(
  parameter int MAX_AXLES = vasc_pkg::MAX_AXLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input requests.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [vasc_pkg::TIME_W-1:0]      s_axis_tdata,  // [31:0] event_time
  input  logic [vasc_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] operation
  // Result requests.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] heavy_vehicle, [8:1] axle_total, [30:9] speed_tenths_kmh,
  // [31] speed_saturated
  output logic [31:0]                      m_axis_tdata,
  // Configuration writes.
  input  logic                             cfg_we,
  input  logic [vasc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vasc_pkg::DIST_W-1:0]      cfg_data
);

  // The block is either waiting for a vehicle or tracking one.
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_READ = 2'b10
  } phase_t;

  localparam logic [vasc_pkg::AXLE_W-1:0] AXLE_LIMIT = vasc_pkg::AXLE_W'(MAX_AXLES);

  // Configuration registers.
  logic [vasc_pkg::DIST_W-1:0]  sensor_distance_mm;
  logic [vasc_pkg::TICK_W-1:0]  timeout_ticks;

  // Reading state.
  phase_t                       phase;
  logic [vasc_pkg::AXLE_W-1:0]  axle_counter;
  logic [vasc_pkg::TIME_W-1:0]  start_time;
  logic                         speed_measured;
  logic [vasc_pkg::SPEED_W-1:0] speed_value;
  logic                         speed_flag;
  logic [vasc_pkg::TICK_W-1:0]  timeout_counter;

  logic                         in_fire;
  logic                         reading;
  vasc_pkg::op_t                op;
  logic [vasc_pkg::TIME_W-1:0]  dt;
  logic                         dt_zero;
  logic [vasc_pkg::TICK_W-1:0]  limit;
  logic [vasc_pkg::TICK_W:0]    tick_inc;
  logic                         closing;
  logic                         div_start;
  logic                         result_load;
  vasc_pkg::result_t            result;
  vasc_pkg::result_t            out_held;
  vasc_pkg::div_status_t        div_status;
  logic [vasc_pkg::SPEED_W-1:0] div_speed;
  logic                         div_active;

  // The divider counts as active through its hand-back cycle, so that a
  // request never sees the speed register before the quotient lands there.
  assign div_active = div_status.busy || div_status.done;

  // A new request is taken when the divider is free and the output register
  // is empty or being emptied in this cycle.
  assign s_axis_tready = !div_active && (!m_axis_tvalid || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser;
  assign reading       = (phase == PH_READ);

  // The time difference wraps modulo 2^32, just like the timestamps.
  assign dt      = s_axis_tdata - start_time;
  assign dt_zero = (dt == '0);

  // A timeout of zero acts as one tick.
  assign limit    = (timeout_ticks == '0) ? vasc_pkg::TICK_W'(1) : timeout_ticks;
  assign tick_inc = {1'b0, timeout_counter} + {{vasc_pkg::TICK_W{1'b0}}, 1'b1};
  assign closing  = reading && (op == vasc_pkg::OP_TICK) && (tick_inc >= {1'b0, limit});

  assign div_start = in_fire && reading && (op == vasc_pkg::OP_SECOND) &&
                     !speed_measured && !dt_zero;

  // A reading that closes gives a result only with a speed and at least two axles.
  assign result_load = in_fire && closing && speed_measured &&
                       (axle_counter >= vasc_pkg::AXLE_W'(2));

  always_comb begin
    result.heavy_vehicle    = (axle_counter > vasc_pkg::AXLE_W'(2));
    result.axle_total       = axle_counter;
    result.speed_tenths_kmh = speed_value;
    result.speed_saturated  = speed_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_distance_mm <= vasc_pkg::DIST_RESET;
      timeout_ticks      <= vasc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vasc_pkg::CFG_DISTANCE: sensor_distance_mm <= cfg_data;
        vasc_pkg::CFG_TIMEOUT:  timeout_ticks      <= cfg_data;
        default: begin
          sensor_distance_mm <= sensor_distance_mm;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      axle_counter    <= '0;
      start_time      <= '0;
      speed_measured  <= 1'b0;
      speed_value     <= '0;
      speed_flag      <= 1'b0;
      timeout_counter <= '0;
    end else begin
      // The quotient arrives while no request can be taken.
      if (div_status.done) begin
        speed_value <= div_speed;
      end
      if (in_fire) begin
        case (phase)
          PH_IDLE: begin
            // Only a first-sensor pulse opens a reading; all else is dropped.
            if (op == vasc_pkg::OP_FIRST) begin
              phase           <= PH_READ;
              axle_counter    <= vasc_pkg::AXLE_W'(1);
              start_time      <= s_axis_tdata;
              speed_measured  <= 1'b0;
              speed_value     <= '0;
              speed_flag      <= 1'b0;
              timeout_counter <= '0;
            end
          end
          PH_READ: begin
            case (op)
              vasc_pkg::OP_FIRST: begin
                if (axle_counter < AXLE_LIMIT) begin
                  axle_counter <= axle_counter + vasc_pkg::AXLE_W'(1);
                end
                timeout_counter <= '0;
              end
              vasc_pkg::OP_SECOND: begin
                // Only the first second-sensor pulse of a reading counts.
                if (!speed_measured) begin
                  speed_measured <= 1'b1;
                  speed_flag     <= dt_zero;
                  if (dt_zero) begin
                    speed_value <= vasc_pkg::SPEED_MAX;
                  end
                end
              end
              vasc_pkg::OP_TICK: begin
                if (closing) begin
                  phase           <= PH_IDLE;
                  axle_counter    <= '0;
                  start_time      <= '0;
                  speed_measured  <= 1'b0;
                  speed_value     <= '0;
                  speed_flag      <= 1'b0;
                  timeout_counter <= '0;
                end else begin
                  timeout_counter <= tick_inc[vasc_pkg::TICK_W-1:0];
                end
              end
              default: begin
                phase <= PH_READ;
              end
            endcase
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

  vasc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sensor_distance_mm),
    .divisor  (dt),
    .status   (div_status),
    .speed    (div_speed)
  );

  vasc_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (result_load),
    .data  (result),
    .valid (m_axis_tvalid),
    .ready (m_axis_tready),
    .held  (out_held)
  );

  assign m_axis_tdata = out_held;

`ifndef SYNTHESIS
  // No request may slip in while the divider still owns the speed register.
  assert property (@(posedge clk) disable iff (rst) div_active |-> !s_axis_tready)
    else $error("request accepted during a division");

  // A division only runs inside an open reading that has its speed pending.
  assert property (@(posedge clk) disable iff (rst)
    div_status.busy |-> (reading && speed_measured))
    else $error("divider active outside a reading");

  // A saturated speed always carries the saturation value.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_held.speed_saturated) |->
      (out_held.speed_tenths_kmh == vasc_pkg::SPEED_MAX))
    else $error("saturated result with wrong speed");

  // Loading a result always leaves the block idle afterwards.
  assert property (@(posedge clk) disable iff (rst) result_load |=> (phase == PH_IDLE))
    else $error("reading did not close after a result");
`endif

endmodule

@@ verif/tb_vehicle_axle_speed_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vehicle_axle_speed_classifier_unit
// Self-checking bench for the axle and speed classifier. Sensor and tick
// requests go in on the input stream. An in-bench model of the reading
// predicts each vehicle result, and the results coming out of the output
// stream are compared with those predictions field by field. Both streams
// idle at random, and the output side is held off once long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_vehicle_axle_speed_classifier_unit;

  localparam int       CLK_HALF       = 4;
  localparam int       RESET_CYCLES   = 12;
  localparam int       IDLE_PERCENT   = 17;
  // The quiet stretch outlasts the divider's hold on the input, so it is enough
  // for any work that has no result to finish before a register write.
  localparam int       SETTLE_CYCLES  = 40;
  localparam int       HOLDOFF_CYCLES = 400;
  // Longest correct stretch without any request moving is the hold-off.
  localparam int       STALL_LIMIT    = 2000;
  localparam int       PHASE_ITEMS    = 75;
  localparam int       PHASE_COUNT    = 6;
  localparam int       MAX_AXLE_COUNT = vasc_pkg::MAX_AXLES_DEF;
  localparam logic [vasc_pkg::TICK_W-1:0] LONG_TIMEOUT = 16'd96;
  // Codes the package leaves unnamed: the spare operation and register index.
  localparam vasc_pkg::op_t      OP_UNUSED  = 2'd3;
  localparam vasc_pkg::cfg_idx_t CFG_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [vasc_pkg::TIME_W-1:0]    s_axis_tdata;   // [31:0] event_time
  logic [vasc_pkg::OP_W-1:0]      s_axis_tuser;   // [1:0] operation
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // [0] heavy_vehicle, [8:1] axle_total, [30:9] speed_tenths_kmh,
  // [31] speed_saturated
  logic [31:0]                    m_axis_tdata;
  logic                           cfg_we;
  logic [vasc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vasc_pkg::DIST_W-1:0]    cfg_data;

  vehicle_axle_speed_classifier_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Configuration as the bench believes the block holds it.
  logic [vasc_pkg::DIST_W-1:0]  cur_distance;
  logic [vasc_pkg::TICK_W-1:0]  cur_timeout;

  // The reading in progress, mirrored from the block's behavior.
  logic                         rd_active;
  logic [vasc_pkg::AXLE_W-1:0]  rd_axles;
  logic [vasc_pkg::TIME_W-1:0]  rd_start;
  logic                         rd_has_speed;
  logic [vasc_pkg::SPEED_W-1:0] rd_speed;
  logic                         rd_sat;
  logic [vasc_pkg::TICK_W-1:0]  rd_ticks;

  // Vehicles that have closed in the model and are still owed by the block.
  vasc_pkg::result_t            expected_vehicles[$];
  vasc_pkg::result_t            got_vehicle;
  vasc_pkg::result_t            want_vehicle;

  int                 error_count;
  int                 live_items;     // non-spare requests that open or reach a reading
  int                 quiet_cycles;
  int                 holdoff_len;    // set by a test, picked up by the receiver
  int                 holdoff_left;
  bit                 steady;         // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Reading model
  // --------------------------------------------------------------------------

  task automatic clear_reading_model();
    rd_active    = 1'b0;
    rd_axles     = '0;
    rd_start     = '0;
    rd_has_speed = 1'b0;
    rd_speed     = '0;
    rd_sat       = 1'b0;
    rd_ticks     = '0;
  endtask

  // Applies one accepted request to the model and queues the vehicle that a
  // closing tick produces, if the reading qualifies.
  task automatic classify_event(input vasc_pkg::op_t op,
                                input logic [vasc_pkg::TIME_W-1:0] stamp);
    logic [vasc_pkg::TIME_W-1:0] dt;
    logic [31:0]                 quotient;
    logic [31:0]                 scaled;
    logic [vasc_pkg::TICK_W-1:0] limit;
    vasc_pkg::result_t           vehicle;
    if (op != OP_UNUSED && (rd_active || op == vasc_pkg::OP_FIRST))
      live_items++;
    if (!rd_active) begin
      // In the idle phase only a first-sensor pulse matters: it opens a
      // reading with one axle. Second pulses, ticks and the spare code drop.
      if (op == vasc_pkg::OP_FIRST) begin
        clear_reading_model();
        rd_active = 1'b1;
        rd_axles  = 8'd1;
        rd_start  = stamp;
      end
    end else begin
      case (op)
        vasc_pkg::OP_FIRST: begin
          if (rd_axles < vasc_pkg::AXLE_W'(MAX_AXLE_COUNT))
            rd_axles = rd_axles + 8'd1;
          rd_ticks = '0;
        end
        vasc_pkg::OP_SECOND: begin
          // Only the first second-sensor pulse of a reading measures speed.
          if (!rd_has_speed) begin
            dt = stamp - rd_start;   // wraps modulo 2^32 on purpose
            if (dt == '0) begin
              rd_speed = vasc_pkg::SPEED_MAX;
              rd_sat   = 1'b1;
            end else begin
              quotient = {16'd0, cur_distance} / dt;
              scaled   = quotient * 32'd36;
              rd_speed = scaled[vasc_pkg::SPEED_W-1:0];
              rd_sat   = 1'b0;
            end
            rd_has_speed = 1'b1;
          end
        end
        vasc_pkg::OP_TICK: begin
          // A timeout of zero acts as one tick.
          limit    = (cur_timeout == '0) ? vasc_pkg::TICK_W'(1) : cur_timeout;
          rd_ticks = rd_ticks + vasc_pkg::TICK_W'(1);
          if (rd_ticks >= limit) begin
            if (rd_has_speed && rd_axles >= 8'd2) begin
              vehicle.heavy_vehicle    = (rd_axles > 8'd2);
              vehicle.axle_total       = rd_axles;
              vehicle.speed_tenths_kmh = rd_speed;
              vehicle.speed_saturated  = rd_sat;
              expected_vehicles.push_back(vehicle);
            end
            clear_reading_model();
          end
        end
        default: ;
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one request from a falling edge and returns at the falling edge
  // after it was taken. Valid stays high into the next request when there is
  // no idle gap, so it is never lowered and raised in the same step.
  task automatic send_event(input vasc_pkg::op_t op,
                            input logic [vasc_pkg::TIME_W-1:0] stamp);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= stamp;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    classify_event(op, stamp);
    @(negedge clk);
  endtask

  // Feeds ticks until the model's reading has timed out.
  task automatic close_reading();
    while (rd_active) send_event(vasc_pkg::OP_TICK, $urandom());
  endtask

  // Brings the block to rest: reading closed, every owed vehicle delivered,
  // and enough quiet cycles for a pending division to finish.
  task automatic settle_block();
    close_reading();
    s_axis_tvalid <= 1'b0;
    while (expected_vehicles.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The write enable is dropped between writes so that it never
  // gets two assignments in one step.
  task automatic write_register(input vasc_pkg::cfg_idx_t idx,
                                input logic [vasc_pkg::DIST_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == vasc_pkg::CFG_DISTANCE)
      cur_distance = value;
    else if (idx == vasc_pkg::CFG_TIMEOUT)
      cur_timeout = value;
    @(negedge clk);
  endtask

  task automatic configure(input logic [vasc_pkg::DIST_W-1:0] distance,
                           input logic [vasc_pkg::TICK_W-1:0] timeout);
    settle_block();
    write_register(vasc_pkg::CFG_DISTANCE, distance);
    write_register(vasc_pkg::CFG_TIMEOUT, timeout);
  endtask

  // Timestamps are mostly uniform, with a share close to the top so that
  // the time difference often wraps.
  function automatic logic [vasc_pkg::TIME_W-1:0] pick_stamp();
    if ($urandom_range(0, 99) < 20)
      return 32'hFFFF_FFFF - vasc_pkg::TIME_W'($urandom_range(0, 20));
    return $urandom();
  endfunction

  // Time differences: zero now and then, many small and distance-sized
  // ones so that speeds come out nonzero, and some arbitrary ones.
  function automatic logic [vasc_pkg::TIME_W-1:0] pick_dt();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      return '0;
    if (pick < 40)
      return vasc_pkg::TIME_W'($urandom_range(1, 16));
    if (pick < 80)
      return vasc_pkg::TIME_W'($urandom_range(1, int'(cur_distance) + 1));
    return $urandom();
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values of both registers, and the requests the idle phase drops.
  task automatic test_reset_defaults();
    send_event(vasc_pkg::OP_SECOND, 32'd5);
    send_event(vasc_pkg::OP_TICK, 32'hFFFF_FFFF);
    send_event(OP_UNUSED, 32'hA5A5_5A5A);
    send_event(vasc_pkg::OP_FIRST, 32'd0);
    send_event(vasc_pkg::OP_FIRST, 32'd50);
    send_event(vasc_pkg::OP_SECOND, 32'd10);   // 1000 / 10 gives 3600 tenths
    send_event(vasc_pkg::OP_SECOND, 32'd11);   // later second pulse is ignored
    send_event(OP_UNUSED, 32'd0);
    // Twenty ticks stay well short of the default timeout of 700.
    repeat (20) send_event(vasc_pkg::OP_TICK, $urandom());
    // Shorten the timeout while the reading is still open; it then closes
    // five ticks later.
    s_axis_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(vasc_pkg::CFG_TIMEOUT, 16'd25);
    close_reading();
  endtask

  // Light and heavy vehicles, zero and wrapped time differences, the top
  // speed, readings that close without a result and short timeouts.
  task automatic test_speed_cases();
    configure(16'd65535, 16'd2);
    // Same timestamp on both sensors: speed saturates; three axles is heavy.
    send_event(vasc_pkg::OP_FIRST, 32'hFFFF_FFFF);
    send_event(vasc_pkg::OP_FIRST, 32'h0000_0001);
    send_event(vasc_pkg::OP_FIRST, 32'h0000_0002);
    send_event(vasc_pkg::OP_SECOND, 32'hFFFF_FFFF);
    send_event(vasc_pkg::OP_SECOND, 32'h0000_0000);
    close_reading();
    // The second timestamp wrapped past zero.
    send_event(vasc_pkg::OP_FIRST, 32'hFFFF_FFF0);
    send_event(vasc_pkg::OP_FIRST, 32'hFFFF_FFF8);
    send_event(vasc_pkg::OP_SECOND, 32'h0000_0010);
    close_reading();
    // One millisecond at the widest spacing: highest unsaturated speed.
    send_event(vasc_pkg::OP_FIRST, 32'd0);
    send_event(vasc_pkg::OP_FIRST, 32'd3);
    send_event(vasc_pkg::OP_SECOND, 32'd1);
    close_reading();
    // A single axle and a missing speed both close without a result.
    send_event(vasc_pkg::OP_FIRST, 32'h8000_0000);
    send_event(vasc_pkg::OP_SECOND, 32'h8000_0005);
    close_reading();
    send_event(vasc_pkg::OP_FIRST, 32'h7FFF_FFFF);
    send_event(vasc_pkg::OP_FIRST, 32'h8000_0000);
    close_reading();
    // The spare register index must leave both registers alone.
    settle_block();
    write_register(CFG_UNUSED, 16'hFFFF);
    send_event(vasc_pkg::OP_FIRST, 32'd100);
    send_event(vasc_pkg::OP_FIRST, 32'd101);
    send_event(vasc_pkg::OP_SECOND, 32'd103);
    close_reading();
    // Narrowest spacing gives speed zero; a timeout of zero closes at once.
    configure(16'd1, 16'd0);
    send_event(vasc_pkg::OP_FIRST, 32'd7);
    send_event(vasc_pkg::OP_FIRST, 32'd8);
    send_event(vasc_pkg::OP_SECOND, 32'd9);
    send_event(vasc_pkg::OP_TICK, 32'd0);
    // An axle between ticks restarts the timeout.
    configure(16'd4000, 16'd3);
    send_event(vasc_pkg::OP_FIRST, 32'd1000);
    send_event(vasc_pkg::OP_TICK, 32'd0);
    send_event(vasc_pkg::OP_TICK, 32'd0);
    send_event(vasc_pkg::OP_FIRST, 32'd1200);
    send_event(vasc_pkg::OP_TICK, 32'd0);
    send_event(vasc_pkg::OP_TICK, 32'd0);
    send_event(vasc_pkg::OP_SECOND, 32'd1040);
    send_event(vasc_pkg::OP_TICK, 32'd0);
  endtask

  // The axle count stops at its ceiling.
  task automatic test_axle_saturation();
    configure(16'd2500, 16'd2);
    repeat (MAX_AXLE_COUNT + 5) send_event(vasc_pkg::OP_FIRST, $urandom());
    send_event(vasc_pkg::OP_SECOND, rd_start + 32'd20);
    close_reading();
  endtask

  // A longer timeout with no idling on either side: the reading stays open
  // through many ticks before it closes.
  task automatic test_long_timeout();
    logic [vasc_pkg::TIME_W-1:0] t0;
    configure(16'($urandom_range(1, 65535)), LONG_TIMEOUT);
    steady = 1'b1;
    t0 = pick_stamp();
    send_event(vasc_pkg::OP_FIRST, t0);
    send_event(vasc_pkg::OP_FIRST, t0 + 32'd300);
    send_event(vasc_pkg::OP_SECOND, t0 + pick_dt());
    close_reading();
    steady = 1'b0;
  endtask

  // The receiver stops for a long stretch while closing readings keep
  // arriving, so the result register fills and the input backs up.
  task automatic test_output_holdoff();
    configure(16'd1800, 16'd1);
    holdoff_len = HOLDOFF_CYCLES;
    repeat (5) begin
      send_event(vasc_pkg::OP_FIRST, 32'd500);
      send_event(vasc_pkg::OP_FIRST, 32'd520);
      send_event(vasc_pkg::OP_SECOND, 32'd500 + vasc_pkg::TIME_W'($urandom_range(0, 40)));
      send_event(vasc_pkg::OP_TICK, $urandom());
    end
  endtask

  // One reading with random content: axles, second pulses, ticks that may
  // close it early and the spare code, then ticks until it closes.
  task automatic random_reading();
    logic [vasc_pkg::TIME_W-1:0] t0;
    int pick;
    t0 = pick_stamp();
    send_event(vasc_pkg::OP_FIRST, t0);
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_event(vasc_pkg::OP_FIRST, $urandom());
      else if (pick < 75)
        send_event(vasc_pkg::OP_SECOND, t0 + pick_dt());
      else if (pick < 92)
        send_event(vasc_pkg::OP_TICK, $urandom());
      else
        send_event(OP_UNUSED, $urandom());
    end
    close_reading();
  endtask

  task automatic test_random_traffic();
    int start_items;
    int pick;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       configure(16'd1, 16'd1);
        1:       configure(16'd65535, 16'd8);
        2:       configure(16'($urandom_range(1, 65535)), 16'($urandom_range(2, 6)));
        3:       configure(16'd1000, 16'd0);
        4:       configure(16'($urandom_range(1, 5000)), 16'd3);
        default: configure(16'd65535, 16'($urandom_range(1, 4)));
      endcase
      // One phase runs with no idling on either side.
      steady = (phase == 2);
      start_items = live_items;
      while (live_items - start_items < PHASE_ITEMS) begin
        // Stray requests in the idle phase, which the block must drop.
        if ($urandom_range(0, 99) < 25) begin
          repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
              send_event(vasc_pkg::OP_SECOND, $urandom());
            else if (pick == 1)
              send_event(vasc_pkg::OP_TICK, $urandom());
            else
              send_event(OP_UNUSED, $urandom());
          end
        end
        random_reading();
      end
      steady = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = vasc_pkg::OP_FIRST;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = vasc_pkg::CFG_DISTANCE;
    cfg_data      = '0;
    steady        = 1'b0;
    holdoff_len   = 0;
    holdoff_left  = 0;
    error_count   = 0;
    live_items    = 0;
    cur_distance  = vasc_pkg::DIST_RESET;
    cur_timeout   = vasc_pkg::TIMEOUT_RESET;
    clear_reading_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_speed_cases();
    test_axle_saturation();
    test_long_timeout();
    test_output_holdoff();
    test_random_traffic();

    // Drain everything still owed, then give the block its latency to show
    // any result nobody asked for.
    settle_block();
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // --------------------------------------------------------------------------

  // Ready changes on the falling edge. A hold-off asked for by a test is
  // counted down here, once per falling edge.
  always @(negedge clk) begin
    if (holdoff_len != 0) begin
      holdoff_left = holdoff_len;
      holdoff_len  = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s is %0d, predicted %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Every result request taken is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_vehicle = vasc_pkg::result_t'(m_axis_tdata);
      if (expected_vehicles.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_axis_tdata, 32'd0);
      end else begin
        want_vehicle = expected_vehicles.pop_front();
        if (got_vehicle.heavy_vehicle !== want_vehicle.heavy_vehicle)
          report_mismatch("heavy_vehicle", 32'(got_vehicle.heavy_vehicle),
                          32'(want_vehicle.heavy_vehicle));
        if (got_vehicle.axle_total !== want_vehicle.axle_total)
          report_mismatch("axle_total", 32'(got_vehicle.axle_total),
                          32'(want_vehicle.axle_total));
        if (got_vehicle.speed_tenths_kmh !== want_vehicle.speed_tenths_kmh)
          report_mismatch("speed_tenths_kmh", 32'(got_vehicle.speed_tenths_kmh),
                          32'(want_vehicle.speed_tenths_kmh));
        if (got_vehicle.speed_saturated !== want_vehicle.speed_saturated)
          report_mismatch("speed_saturated", 32'(got_vehicle.speed_saturated),
                          32'(want_vehicle.speed_saturated));
      end
    end
  end

  // Ends the run if neither stream moves a request for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no request moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
